// File: hdl/wsd_pkg.sv
// shared types and constants for the websocket masked text deframer
package wsd_pkg;

   localparam int LENGTH_WIDTH = 32;
   localparam int OUT_LENGTH_WIDTH = 32;
   localparam int HDR_CNT_WIDTH = 4;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_WIDTH = $clog2(FIFO_DEPTH + 1);

   localparam logic [3:0] OPCODE_MASK_TEXT = 4'h1;
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;
   localparam logic [HDR_CNT_WIDTH-1:0] EXT16_BYTES = HDR_CNT_WIDTH'(2);
   localparam logic [HDR_CNT_WIDTH-1:0] EXT64_BYTES = HDR_CNT_WIDTH'(8);
   localparam logic [HDR_CNT_WIDTH-1:0] MASK_BYTES = HDR_CNT_WIDTH'(4);

   typedef enum logic [2:0] {
      PH_HDR0   = 3'd0,
      PH_HDR1   = 3'd1,
      PH_EXT    = 3'd2,
      PH_MASK   = 3'd3,
      PH_PAY    = 3'd4,
      PH_IGNORE = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      FORM_SHORT = 2'd0,
      FORM_EXT16 = 2'd1,
      FORM_EXT64 = 2'd2
   } form_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_INCOMPLETE = 3'd1,
      ST_NOT_TEXT   = 3'd2,
      ST_NOT_MASKED = 3'd3,
      ST_TOO_LONG   = 3'd4
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                    item_kind;
      logic [7:0]                  payload_byte;
      status_type                  frame_status;
      logic [OUT_LENGTH_WIDTH-1:0] payload_length;
      logic                        last;
   } result_type;

   typedef struct packed {
      logic       pay_valid;
      logic       stat_valid;
      result_type pay;
      result_type stat;
   } push_type;

endpackage

// File: hdl/wsd_req_if.sv
// input byte channel
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_buffer;

   modport source (output valid, output rx_byte, output end_of_buffer, input ready);
   modport sink (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

// File: hdl/wsd_rsp_if.sv
// result channel
interface wsd_rsp_if
   import wsd_pkg::*;
();
   logic                        valid;
   logic                        ready;
   logic                        item_kind;
   logic [7:0]                  payload_byte;
   logic [2:0]                  frame_status;
   logic [OUT_LENGTH_WIDTH-1:0] payload_length;
   logic                        last;

   modport source (output valid, output item_kind, output payload_byte,
                   output frame_status, output payload_length, output last,
                   input ready);
   modport sink (input valid, input item_kind, input payload_byte,
                 input frame_status, input payload_length, input last,
                 output ready);
endinterface

// File: hdl/wsd_parser.sv
// frame header parser, mask key capture and payload unmasking
module wsd_parser
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic       end_of_buffer,
   output push_type   push
);

   phase_type                 phase_ff, phase_in;
   logic [HDR_CNT_WIDTH-1:0]  hdr_cnt_ff, hdr_cnt_in;
   form_type                  form_ff, form_in;
   logic [LENGTH_WIDTH-1:0]   ext_ff, ext_in;
   logic                      too_long_ff, too_long_in;
   logic [LENGTH_WIDTH-1:0]   pay_cnt_ff, pay_cnt_in;
   logic                      opcode_bad_ff, opcode_bad_in;
   logic                      mask_seen_ff, mask_seen_in;
   logic [7:0]                key_ff [4];
   logic                      key_we;
   logic [6:0]                len7;
   logic [HDR_CNT_WIDTH-1:0]  ext_bytes;
   logic [LENGTH_WIDTH+OUT_LENGTH_WIDTH-1:0] ext_wide;
   status_type                status;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR0;
         hdr_cnt_ff    <= '0;
         form_ff       <= FORM_SHORT;
         ext_ff        <= '0;
         too_long_ff   <= 1'b0;
         pay_cnt_ff    <= '0;
         opcode_bad_ff <= 1'b0;
         mask_seen_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         form_ff       <= form_in;
         ext_ff        <= ext_in;
         too_long_ff   <= too_long_in;
         pay_cnt_ff    <= pay_cnt_in;
         opcode_bad_ff <= opcode_bad_in;
         mask_seen_ff  <= mask_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_ff[hdr_cnt_ff[1:0]] <= rx_byte;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      form_in       = form_ff;
      ext_in        = ext_ff;
      too_long_in   = too_long_ff;
      pay_cnt_in    = pay_cnt_ff;
      opcode_bad_in = opcode_bad_ff;
      mask_seen_in  = mask_seen_ff;
      key_we        = 1'b0;
      len7          = rx_byte[6:0];
      ext_bytes     = (form_ff == FORM_EXT16) ? EXT16_BYTES : EXT64_BYTES;

      push.pay_valid           = 1'b0;
      push.pay.item_kind       = KIND_PAYLOAD;
      push.pay.payload_byte    = rx_byte ^ key_ff[pay_cnt_ff[1:0]];
      push.pay.frame_status    = ST_OK;
      push.pay.payload_length  = '0;
      push.pay.last            = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_HDR0: begin
               opcode_bad_in = rx_byte[3:0] != OPCODE_MASK_TEXT;
               phase_in      = PH_HDR1;
            end
            PH_HDR1: begin
               mask_seen_in = rx_byte[7];
               hdr_cnt_in   = '0;
               ext_in       = '0;
               too_long_in  = 1'b0;
               if (opcode_bad_ff) begin
                  phase_in = PH_IGNORE;
               end else if (len7 == LEN7_EXT16) begin
                  form_in  = FORM_EXT16;
                  phase_in = PH_EXT;
               end else if (len7 == LEN7_EXT64) begin
                  form_in  = FORM_EXT64;
                  phase_in = PH_EXT;
               end else begin
                  form_in  = FORM_SHORT;
                  ext_in   = LENGTH_WIDTH'(len7);
                  phase_in = rx_byte[7] ? PH_MASK : PH_IGNORE;
               end
            end
            PH_EXT: begin
               too_long_in = too_long_ff | (ext_ff[LENGTH_WIDTH-1 -: 8] != 8'd0);
               ext_in      = {ext_ff[LENGTH_WIDTH-9:0], rx_byte};
               hdr_cnt_in  = hdr_cnt_ff + HDR_CNT_WIDTH'(1);
               if (hdr_cnt_in >= ext_bytes) begin
                  if (mask_seen_ff && !too_long_in) begin
                     phase_in   = PH_MASK;
                     hdr_cnt_in = '0;
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end
            end
            PH_MASK: begin
               key_we     = 1'b1;
               hdr_cnt_in = hdr_cnt_ff + HDR_CNT_WIDTH'(1);
               if (hdr_cnt_in >= MASK_BYTES) begin
                  phase_in   = PH_PAY;
                  pay_cnt_in = '0;
               end
            end
            PH_PAY: begin
               if (pay_cnt_ff < ext_ff) begin
                  push.pay_valid = 1'b1;
                  pay_cnt_in     = pay_cnt_ff + LENGTH_WIDTH'(1);
               end
            end
            PH_IGNORE: begin
            end
            default: begin
            end
         endcase
      end

      // status reflects the state after this byte
      if (phase_in == PH_HDR0 || phase_in == PH_HDR1) begin
         status = ST_INCOMPLETE;
      end else if (opcode_bad_in) begin
         status = ST_NOT_TEXT;
      end else if (phase_in == PH_EXT) begin
         status = ST_INCOMPLETE;
      end else if (!mask_seen_in) begin
         status = ST_NOT_MASKED;
      end else if (too_long_in) begin
         status = ST_TOO_LONG;
      end else if (phase_in == PH_MASK) begin
         status = ST_INCOMPLETE;
      end else if (pay_cnt_in < ext_in) begin
         status = ST_INCOMPLETE;
      end else begin
         status = ST_OK;
      end

      ext_wide = {{OUT_LENGTH_WIDTH{1'b0}}, ext_in};

      push.stat_valid          = accept && end_of_buffer;
      push.stat.item_kind      = KIND_STATUS;
      push.stat.payload_byte   = 8'd0;
      push.stat.frame_status   = status;
      push.stat.payload_length = (status == ST_OK) ? ext_wide[OUT_LENGTH_WIDTH-1:0] : '0;
      push.stat.last           = 1'b1;

      if (accept && end_of_buffer) begin
         phase_in      = PH_HDR0;
         hdr_cnt_in    = '0;
         form_in       = FORM_SHORT;
         ext_in        = '0;
         too_long_in   = 1'b0;
         pay_cnt_in    = '0;
         opcode_bad_in = 1'b0;
         mask_seen_in  = 1'b0;
      end
   end

endmodule

// File: hdl/wsd_out_fifo.sv
// result queue taking up to two results per cycle
module wsd_out_fifo
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space_ok,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_WIDTH-1:0] count_ff, count_in;
   logic [FIFO_PTR_WIDTH-1:0] stat_ptr;
   logic                      pop;

   assign space_ok  = count_ff <= FIFO_CNT_WIDTH'(FIFO_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign stat_ptr  = wr_ptr_ff + FIFO_PTR_WIDTH'(push.pay_valid);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_WIDTH'(push.pay_valid)
                            + FIFO_PTR_WIDTH'(push.stat_valid);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_WIDTH'(pop);
      count_in  = count_ff + FIFO_CNT_WIDTH'(push.pay_valid)
                           + FIFO_CNT_WIDTH'(push.stat_valid)
                           - FIFO_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.pay_valid) begin
         mem_ff[wr_ptr_ff] <= push.pay;
      end
      if (push.stat_valid) begin
         mem_ff[stat_ptr] <= push.stat;
      end
   end

endmodule

// File: hdl/websocket_masked_text_deframer.sv
// Top level of the websocket masked text frame deframer. One buffer byte is
// accepted per cycle; the header parser and payload unmasking finish each byte
// in that cycle and write its results into a four-entry result queue. A byte
// makes zero, one or two result transactions (an unmasked payload byte and, on
// the end mark, the frame status), so the sustained rate is one byte per cycle
// while results are drained, and a byte that makes two results needs two
// transfers on the result channel. Input is held off while fewer than two queue
// entries are free.
module websocket_masked_text_deframer
   import wsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   wsd_req_if.sink   req,
   wsd_rsp_if.source rsp
);

   push_type   push;
   logic       space_ok;
   logic       accept;
   result_type head;

   assign req.ready = space_ok;
   assign accept    = req.valid && space_ok;

   wsd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req.rx_byte),
      .end_of_buffer (req.end_of_buffer),
      .push          (push)
   );

   wsd_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (head)
   );

   assign rsp.item_kind      = head.item_kind;
   assign rsp.payload_byte   = head.payload_byte;
   assign rsp.frame_status   = head.frame_status;
   assign rsp.payload_length = head.payload_length;
   assign rsp.last           = head.last;

endmodule

// File: tb/sv/tb_websocket_masked_text_deframer.sv
// self-checking testbench for the websocket masked text frame deframer
module tb_websocket_masked_text_deframer
   import wsd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] b;
      logic       eob;
   } rx_beat_type;

   class frame_tracker;
      phase_type                phase;
      logic [HDR_CNT_WIDTH-1:0] hdr_cnt;
      form_type                 form;
      logic [63:0]              ext_len;
      logic [7:0]               key [4];
      logic [63:0]              pay_cnt;
      bit                       op_bad;
      bit                       masked;
      result_type               pending_items [$];
      int                       errors;
      int                       bytes_in;
      int                       payload_seen;
      int                       status_seen [5];

      function new();
         errors = 0;
         bytes_in = 0;
         payload_seen = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear();
      endfunction

      function void clear();
         phase = PH_HDR0;
         hdr_cnt = '0;
         form = FORM_SHORT;
         ext_len = '0;
         foreach (key[i]) key[i] = '0;
         pay_cnt = '0;
         op_bad = 1'b0;
         masked = 1'b0;
      endfunction

      function bit too_long();
         return (ext_len >> LENGTH_WIDTH) != 0;
      endfunction

      function void close_header();
         if (!masked || too_long()) begin
            phase = PH_IGNORE;
         end else begin
            phase = PH_MASK;
            hdr_cnt = '0;
         end
      endfunction

      function status_type final_status();
         if (phase == PH_HDR0 || phase == PH_HDR1) return ST_INCOMPLETE;
         if (op_bad) return ST_NOT_TEXT;
         if (phase == PH_EXT) return ST_INCOMPLETE;
         if (!masked) return ST_NOT_MASKED;
         if (too_long()) return ST_TOO_LONG;
         if (phase == PH_MASK) return ST_INCOMPLETE;
         if (pay_cnt < ext_len) return ST_INCOMPLETE;
         return ST_OK;
      endfunction

      function int pending();
         return pending_items.size();
      endfunction

      // one accepted input transaction
      function void note_byte(logic [7:0] b, logic eob);
         result_type r;
         logic [6:0] l7;
         status_type st;
         bytes_in++;
         case (phase)
            PH_HDR0: begin
               op_bad = b[3:0] != OPCODE_MASK_TEXT;
               phase = PH_HDR1;
            end
            PH_HDR1: begin
               l7 = b[6:0];
               masked = b[7];
               hdr_cnt = '0;
               ext_len = '0;
               if (op_bad) begin
                  phase = PH_IGNORE;
               end else if (l7 == LEN7_EXT16) begin
                  form = FORM_EXT16;
                  phase = PH_EXT;
               end else if (l7 == LEN7_EXT64) begin
                  form = FORM_EXT64;
                  phase = PH_EXT;
               end else begin
                  form = FORM_SHORT;
                  ext_len = {57'd0, l7};
                  close_header();
               end
            end
            PH_EXT: begin
               ext_len = {ext_len[55:0], b};
               hdr_cnt++;
               if (hdr_cnt >= ((form == FORM_EXT16) ? EXT16_BYTES : EXT64_BYTES))
                  close_header();
            end
            PH_MASK: begin
               key[hdr_cnt[1:0]] = b;
               hdr_cnt++;
               if (hdr_cnt >= MASK_BYTES) begin
                  phase = PH_PAY;
                  pay_cnt = '0;
               end
            end
            PH_PAY: begin
               if (pay_cnt < ext_len) begin
                  r = '0;
                  r.item_kind = KIND_PAYLOAD;
                  r.payload_byte = b ^ key[pay_cnt[1:0]];
                  pending_items.push_back(r);
                  pay_cnt++;
               end
            end
            default: ;
         endcase
         if (eob) begin
            st = final_status();
            r = '0;
            r.item_kind = KIND_STATUS;
            r.frame_status = st;
            r.payload_length = (st == ST_OK) ? ext_len[OUT_LENGTH_WIDTH-1:0] : '0;
            r.last = 1'b1;
            pending_items.push_back(r);
            clear();
         end
      endfunction

      // one accepted result transaction
      function void check_item(result_type got);
         result_type exp;
         if (pending_items.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h", $time, got);
            errors++;
            return;
         end
         exp = pending_items.pop_front();
         if (exp.item_kind == KIND_PAYLOAD) payload_seen++;
         else status_seen[exp.frame_status]++;
         if (got.item_kind !== exp.item_kind) begin
            $display("%0t item_kind: expected %0d, actual %0d", $time, exp.item_kind,
                     got.item_kind);
            errors++;
         end
         if (got.payload_byte !== exp.payload_byte) begin
            $display("%0t payload_byte: expected %h, actual %h", $time, exp.payload_byte,
                     got.payload_byte);
            errors++;
         end
         if (got.frame_status !== exp.frame_status) begin
            $display("%0t frame_status: expected %0d, actual %0d", $time, exp.frame_status,
                     got.frame_status);
            errors++;
         end
         if (got.payload_length !== exp.payload_length) begin
            $display("%0t payload_length: expected %h, actual %h", $time,
                     exp.payload_length, got.payload_length);
            errors++;
         end
         if (got.last !== exp.last) begin
            $display("%0t last: expected %0d, actual %0d", $time, exp.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   sender_done;

   wsd_req_if req_ch ();
   wsd_rsp_if rsp_ch ();

   websocket_masked_text_deframer dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   frame_tracker tracker = new();
   rx_beat_type  beats [$];

   function automatic void add_beat(logic [7:0] b, logic eob);
      rx_beat_type t;
      t.b = b;
      t.eob = eob;
      beats.push_back(t);
   endfunction

   function automatic void add_directed();
      // lone header byte
      add_beat(8'h81, 1'b1);
      // wrong opcode
      add_beat(8'h82, 1'b0);
      add_beat(8'h85, 1'b1);
      // mask bit clear
      add_beat(8'h81, 1'b0);
      add_beat(8'h03, 1'b1);
      // empty masked payload, ends on last key byte
      add_beat(8'h81, 1'b0);
      add_beat(8'h80, 1'b0);
      add_beat(8'hFF, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'hA5, 1'b0);
      add_beat(8'h5A, 1'b1);
      // 64-bit length beyond the accepted width
      add_beat(8'hF1, 1'b0);
      add_beat(8'hFF, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h01, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h00, 1'b0);
      add_beat(8'h00, 1'b1);
      // cut inside the 16-bit length
      add_beat(8'h01, 1'b0);
      add_beat(8'hFE, 1'b0);
      add_beat(8'h00, 1'b1);
   endfunction

   function automatic void add_random_buffer();
      rx_beat_type frame_q [$];
      rx_beat_type t;
      logic [7:0]  hdr0;
      logic [7:0]  hdr1;
      logic [63:0] len;
      int          pick;
      int          pay_n;
      int          n;
      t.eob = 1'b0;
      if ($urandom_range(0, 99) < 6) begin
         n = $urandom_range(1, 12);
         repeat (n) begin
            t.b = 8'($urandom);
            frame_q.push_back(t);
         end
      end else begin
         hdr0 = 8'($urandom);
         if ($urandom_range(0, 99) < 85) hdr0[3:0] = OPCODE_MASK_TEXT;
         hdr1 = '0;
         hdr1[7] = $urandom_range(0, 99) < 90;
         t.b = hdr0;
         frame_q.push_back(t);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            len = ($urandom_range(0, 9) == 0) ? 64'd125 : 64'($urandom_range(0, 24));
            hdr1[6:0] = len[6:0];
            t.b = hdr1;
            frame_q.push_back(t);
         end else if (pick < 80) begin
            case ($urandom_range(0, 19))
               0: len = 64'($urandom_range(0, 65535));
               1, 2: len = 64'($urandom_range(0, 300));
               default: len = 64'($urandom_range(0, 40));
            endcase
            hdr1[6:0] = LEN7_EXT16;
            t.b = hdr1;
            frame_q.push_back(t);
            t.b = len[15:8];
            frame_q.push_back(t);
            t.b = len[7:0];
            frame_q.push_back(t);
         end else begin
            case ($urandom_range(0, 4))
               0, 1: len = 64'($urandom_range(0, 40));
               2: len = {32'd0, 32'($urandom)};
               3: begin
                  len = {32'($urandom), 32'($urandom)};
                  if (len[63:32] == 0) len[32] = 1'b1;
               end
               default: len = 64'd1 << $urandom_range(32, 63);
            endcase
            hdr1[6:0] = LEN7_EXT64;
            t.b = hdr1;
            frame_q.push_back(t);
            for (int i = 7; i >= 0; i--) begin
               t.b = len[i*8 +: 8];
               frame_q.push_back(t);
            end
         end
         repeat (4) begin
            t.b = 8'($urandom);
            frame_q.push_back(t);
         end
         pay_n = (len > 400) ? $urandom_range(0, 8) : int'(len);
         repeat (pay_n) begin
            t.b = 8'($urandom);
            frame_q.push_back(t);
         end
         if ($urandom_range(0, 99) < 25) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               t.b = 8'($urandom);
               frame_q.push_back(t);
            end
         end
         if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, frame_q.size());
            while (frame_q.size() > n) void'(frame_q.pop_back());
         end
      end
      frame_q[frame_q.size()-1].eob = 1'b1;
      foreach (frame_q[i]) beats.push_back(frame_q[i]);
   endfunction

   task automatic idle_input(input int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drive_beat(input rx_beat_type t);
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= t.b;
      req_ch.end_of_buffer <= t.eob;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_byte(t.b, t.eob);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin : sender
      int gap;
      int calm_left;
      int r;
      int pause_at;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= '0;
      req_ch.end_of_buffer <= 1'b0;
      calm_left = 0;
      add_directed();
      while (beats.size() < 1124) add_random_buffer();
      pause_at = beats.size() / 2;
      @(posedge clock);
      while (reset) @(posedge clock);
      for (int i = 0; i < beats.size(); i++) begin
         gap = 0;
         if (calm_left > 0) begin
            calm_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2) calm_left = $urandom_range(40, 120);
            else if (r < 60) gap = 0;
            else if (r < 90) gap = $urandom_range(1, 3);
            else gap = $urandom_range(5, 30);
         end
         if (gap > 0) idle_input(gap);
         drive_beat(beats[i]);
         // drain everything before going on
         if (i == pause_at) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (tracker.pending() != 0);
         end
      end
      req_ch.valid <= 1'b0;
      sender_done = 1'b1;
   end

   initial begin : receiver
      int hold_left;
      int calm_left;
      int r;
      bit long_done;
      result_type got;
      hold_left = 0;
      calm_left = 0;
      long_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.item_kind = kind_type'(rsp_ch.item_kind);
            got.payload_byte = rsp_ch.payload_byte;
            got.frame_status = status_type'(rsp_ch.frame_status);
            got.payload_length = rsp_ch.payload_length;
            got.last = rsp_ch.last;
            tracker.check_item(got);
         end
         // long back-pressure so the block fills and stalls its input
         if (!long_done && tracker.bytes_in >= 400) begin
            long_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left == 0 && calm_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 3) calm_left = $urandom_range(40, 120);
            else if (r >= 95) hold_left = $urandom_range(10, 40);
            else if (r >= 70) hold_left = $urandom_range(1, 3);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (calm_left > 0) calm_left--;
            rsp_ch.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   initial begin : finale
      wait (sender_done);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (tracker.pending() != 0) begin
         $display("%0t leftover results: expected 0, actual %0d", $time, tracker.pending());
         tracker.errors++;
      end
      $display("covered %0d bytes, %0d payload transactions, %0d frame statuses",
               tracker.bytes_in, tracker.payload_seen,
               tracker.status_seen[0] + tracker.status_seen[1] + tracker.status_seen[2] +
               tracker.status_seen[3] + tracker.status_seen[4]);
      $display("statuses: ok %0d, incomplete %0d, not text %0d, not masked %0d, too long %0d",
               tracker.status_seen[ST_OK], tracker.status_seen[ST_INCOMPLETE],
               tracker.status_seen[ST_NOT_TEXT], tracker.status_seen[ST_NOT_MASKED],
               tracker.status_seen[ST_TOO_LONG]);
      if (tracker.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: files.f
hdl/wsd_pkg.sv
hdl/wsd_req_if.sv
hdl/wsd_rsp_if.sv
hdl/wsd_parser.sv
hdl/wsd_out_fifo.sv
hdl/websocket_masked_text_deframer.sv
tb/sv/tb_websocket_masked_text_deframer.sv
